// ----- rtl/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Command, place and status codes, default sizes and the per-cell control.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned CapRegWidth = 7;
  localparam int unsigned PosWidth    = 7;

  localparam logic [CapRegWidth-1:0] CapReset = CapRegWidth'(64);

  typedef enum logic [1:0] {
    CmdInsert  = 2'd0,
    CmdRemove  = 2'd1,
    CmdReplace = 2'd2,
    CmdRead    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PlaceFront = 2'd0,
    PlacePos   = 2'd1,
    PlaceBack  = 2'd2
  } place_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadPos = 2'd3
  } status_e;

  // one-cycle action broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // open a hole at the slot, cells above take from below
    logic rem;  // close the slot, cells at and above take from above
    logic wr;   // overwrite the slot
  } cell_ctrl_t;

endpackage

// ----- rtl/ale_cell.sv -----
// ----------------------------------------------------------------------------
// ale_cell: one storage cell of the list chain
// Holds one entry and loads from its lower or upper neighbor on shifts.
// ----------------------------------------------------------------------------
module ale_cell #(
  parameter int unsigned DATA_WIDTH = ale_pkg::DataWidth,
  parameter int unsigned SLOT_W     = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  ale_pkg::cell_ctrl_t   ctrl_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  localparam logic [SLOT_W-1:0] Idx = SLOT_W'(INDEX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  hit, above;

  assign hit   = (slot_i == Idx);
  assign above = (Idx > slot_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (above) begin
        entry_d = prev_i;
      end else if (hit) begin
        entry_d = data_i;
      end
    end else if (ctrl_i.rem) begin
      if (above || hit) begin
        entry_d = next_i;
      end
    end else if (ctrl_i.wr && hit) begin
      entry_d = data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // drive the read bus only from the addressed cell
  assign tap_o   = hit ? entry_q : '0;

endmodule

// ----- rtl/array_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// array_list_engine_unit: ordered word list on a chain of shift cells
// Insert, remove, replace and read at front, 1-based position or back.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd_i, place_i, position_i, data_in_i with start
//   high; the transaction is taken at a rising edge where busy is low.
//   Result channel: done_o pulses for one cycle with status_o, data_out_o,
//   entry_count_o, is_empty_o and is_full_o. The receiver cannot stall, so
//   every result must be captured in its done cycle.
//   Sequence: the accepting edge registers the checked request and raises
//   busy; the execute edge registers the result and raises done_o. No new
//   command is taken while busy is high, but one can be taken while done_o
//   is high. The check step verifies the request and resolves the slot; the
//   execute step moves every cell of the chain at once (shift up, shift down
//   or single write) and reads the addressed cell through the one-hot read bus.
//   Configuration: cfg_we_i with cfg_wdata_i writes the capacity register;
//   write it only while busy is low and no result is pending. Zero acts as
//   one, values above CAPACITY act as CAPACITY.
//   Reset: count goes to zero and capacity to 64; cell contents are left
//   as they are and are never read before being written.
// ----------------------------------------------------------------------------
module array_list_engine_unit #(
  parameter int unsigned CAPACITY   = ale_pkg::Capacity,
  parameter int unsigned DATA_WIDTH = ale_pkg::DataWidth,
  localparam int unsigned CntW      = $clog2(CAPACITY + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      cmd_i,
  input  logic [1:0]                      place_i,
  input  logic [ale_pkg::PosWidth-1:0]    position_i,
  input  logic [DATA_WIDTH-1:0]           data_in_i,
  input  logic                            cfg_we_i,
  input  logic [ale_pkg::CapRegWidth-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [DATA_WIDTH-1:0]           data_out_o,
  output logic [CntW-1:0]                 entry_count_o,
  output logic                            is_empty_o,
  output logic                            is_full_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW  = (CntW > ale_pkg::CapRegWidth) ? CntW
                                                                : ale_pkg::CapRegWidth;
  localparam logic [CmpW-1:0] CapMax = CmpW'(CAPACITY);

  // registers
  logic [ale_pkg::CapRegWidth-1:0] cap_q;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            busy_q;
  ale_pkg::cell_ctrl_t             ctrl_q, ctrl_d;
  logic                            rd_q, rd_d;
  ale_pkg::status_e                st_q, st_d;
  logic [SlotW-1:0]                slot_q, slot_d;
  logic [DATA_WIDTH-1:0]           data_q;
  logic                            done_q;
  logic [1:0]                      status_out_q;
  logic [DATA_WIDTH-1:0]           dout_q, dout_d;
  logic                            empty_q, full_q;

  logic                            accept;
  logic [CmpW-1:0]                 cap_ext, eff_cap, cnt_ext, pos_ext, slot_w, cnt_new_ext;
  logic                            list_full, list_empty, place_ok, ok;
  logic [CntW-1:0]                 count_new;
  ale_pkg::cell_ctrl_t             cell_ctrl;

  logic [DATA_WIDTH-1:0]           entry [CAPACITY];
  logic [DATA_WIDTH-1:0]           tap   [CAPACITY];
  logic [DATA_WIDTH-1:0]           rd_word;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // effective capacity, clamped to 1..CAPACITY
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CapMax) begin
      eff_cap = CapMax;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // request check and slot resolution
  always_comb begin
    cnt_ext    = CmpW'(count_q);
    pos_ext    = CmpW'(position_i);
    list_full  = (cnt_ext >= eff_cap);
    list_empty = (count_q == '0);
    place_ok   = 1'b0;
    slot_w     = '0;
    case (place_i)
      ale_pkg::PlaceFront: begin
        place_ok = 1'b1;
      end
      ale_pkg::PlaceBack: begin
        place_ok = 1'b1;
        slot_w   = (cmd_i == ale_pkg::CmdInsert) ? cnt_ext : cnt_ext - CmpW'(1);
      end
      ale_pkg::PlacePos: begin
        place_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
        slot_w   = pos_ext - CmpW'(1);
      end
      default: begin
        place_ok = 1'b0;
      end
    endcase

    if (cmd_i == ale_pkg::CmdInsert) begin
      st_d = list_full ? ale_pkg::StFull
           : (!place_ok ? ale_pkg::StBadPos : ale_pkg::StOk);
    end else begin
      st_d = list_empty ? ale_pkg::StEmpty
           : (!place_ok ? ale_pkg::StBadPos : ale_pkg::StOk);
    end
    ok = (st_d == ale_pkg::StOk);

    ctrl_d.ins = ok && (cmd_i == ale_pkg::CmdInsert);
    ctrl_d.rem = ok && (cmd_i == ale_pkg::CmdRemove);
    ctrl_d.wr  = ok && (cmd_i == ale_pkg::CmdReplace);
    rd_d       = ok && ((cmd_i == ale_pkg::CmdRemove) || (cmd_i == ale_pkg::CmdRead));
    slot_d     = slot_w[SlotW-1:0];
  end

  // hold the checked request for the execute cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ctrl_q <= '0;
      rd_q   <= 1'b0;
    end else begin
      busy_q <= accept;
      ctrl_q <= accept ? ctrl_d : '0;
      rd_q   <= accept && rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q   <= st_d;
      slot_q <= slot_d;
      data_q <= data_in_i;
    end
  end

  // chain of cells
  assign cell_ctrl = ctrl_q;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = entry[k+1];
    end

    ale_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .SLOT_W    (SlotW),
      .INDEX     (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .slot_i (slot_q),
      .data_i (data_q),
      .prev_i (prev_w),
      .next_i (next_w),
      .entry_o(entry[k]),
      .tap_o  (tap[k])
    );
  end

  // one-hot read bus
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | tap[k];
    end
  end

  // count update and result formation
  always_comb begin
    count_new = count_q;
    if (ctrl_q.ins) begin
      count_new = count_q + CntW'(1);
    end else if (ctrl_q.rem) begin
      count_new = count_q - CntW'(1);
    end
    count_d     = busy_q ? count_new : count_q;
    cnt_new_ext = CmpW'(count_new);
    dout_d      = rd_q ? rd_word : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= ale_pkg::CapReset;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      done_q  <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_out_q <= st_q;
      dout_q       <= dout_d;
      empty_q      <= (count_new == '0);
      full_q       <= (cnt_new_ext >= eff_cap);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_out_q;
  assign data_out_o    = dout_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

endmodule
